// ===== rtl/core/ppp_pkg.sv =====
package ppp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int REG_W     = 31;
   localparam int PROD_W    = WORD_W + REG_W;
   localparam int MAG_W     = PROD_W - 1;
   localparam int DIV_CELLS = MAG_W;
   localparam int LATENCY   = DIV_CELLS + 3;

   localparam logic [REG_W-1:0] FOCAL_RESET    = REG_W'(64'd525 << FRAC_BITS);
   localparam logic [REG_W-1:0] CENTER_X_RESET = REG_W'((64'd639 << FRAC_BITS) >> 1);
   localparam logic [REG_W-1:0] CENTER_Y_RESET = REG_W'((64'd479 << FRAC_BITS) >> 1);

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_ZERO = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_FOCAL_X  = 2'd0,
      CSR_FOCAL_Y  = 2'd1,
      CSR_CENTER_X = 2'd2,
      CSR_CENTER_Y = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] point_x;
      logic signed [WORD_W-1:0] point_y;
      logic signed [WORD_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pixel_u;
      logic signed [WORD_W-1:0] pixel_v;
      logic signed [WORD_W-1:0] depth_out;
      status_type               status;
   } rsp_type;

   typedef struct packed {
      logic [REG_W-1:0] focal_x;
      logic [REG_W-1:0] focal_y;
      logic [REG_W-1:0] center_x;
      logic [REG_W-1:0] center_y;
   } cfg_type;

   // one divider stage: acc holds remaining dividend bits with quotient bits shifted in
   typedef struct packed {
      logic                     valid;
      logic                     zero;
      logic                     neg_u;
      logic                     neg_v;
      logic [MAG_W-1:0]         acc_u;
      logic [MAG_W-1:0]         acc_v;
      logic [WORD_W-1:0]        rem_u;
      logic [WORD_W-1:0]        rem_v;
      logic [WORD_W-1:0]        divisor;
      logic signed [WORD_W-1:0] depth;
   } cell_type;

endpackage

// ===== rtl/core/ppp_mul.sv =====
module ppp_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  ppp_pkg::req_type  req,
   input  ppp_pkg::cfg_type  cfg,
   output ppp_pkg::cell_type cell_out
);
   import ppp_pkg::*;

   logic                     valid_ff;
   logic signed [PROD_W-1:0] prod_u_ff, prod_u_in;
   logic signed [PROD_W-1:0] prod_v_ff, prod_v_in;
   logic signed [WORD_W-1:0] z_ff;
   cell_type                 cell_ff, cell_in;
   logic signed [PROD_W-1:0] abs_u, abs_v;
   logic [WORD_W-1:0]        abs_z;

   // signed point times unsigned focal length
   always_comb begin
      prod_u_in = $signed({{(PROD_W-WORD_W){req.point_x[WORD_W-1]}}, req.point_x})
                * $signed({{(PROD_W-REG_W){1'b0}}, cfg.focal_x});
      prod_v_in = $signed({{(PROD_W-WORD_W){req.point_y[WORD_W-1]}}, req.point_y})
                * $signed({{(PROD_W-REG_W){1'b0}}, cfg.focal_y});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      prod_u_ff <= prod_u_in;
      prod_v_ff <= prod_v_in;
      z_ff      <= req.point_z;
   end

   // magnitudes and quotient signs
   always_comb begin
      abs_u = prod_u_ff[PROD_W-1] ? -prod_u_ff : prod_u_ff;
      abs_v = prod_v_ff[PROD_W-1] ? -prod_v_ff : prod_v_ff;
      abs_z = z_ff[WORD_W-1] ? WORD_W'(-z_ff) : WORD_W'(z_ff);
      cell_in.valid   = valid_ff;
      cell_in.zero    = (z_ff == '0);
      cell_in.neg_u   = prod_u_ff[PROD_W-1] ^ z_ff[WORD_W-1];
      cell_in.neg_v   = prod_v_ff[PROD_W-1] ^ z_ff[WORD_W-1];
      cell_in.acc_u   = abs_u[MAG_W-1:0];
      cell_in.acc_v   = abs_v[MAG_W-1:0];
      cell_in.rem_u   = '0;
      cell_in.rem_v   = '0;
      cell_in.divisor = abs_z;
      cell_in.depth   = z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.zero    <= cell_in.zero;
      cell_ff.neg_u   <= cell_in.neg_u;
      cell_ff.neg_v   <= cell_in.neg_v;
      cell_ff.acc_u   <= cell_in.acc_u;
      cell_ff.acc_v   <= cell_in.acc_v;
      cell_ff.rem_u   <= cell_in.rem_u;
      cell_ff.rem_v   <= cell_in.rem_v;
      cell_ff.divisor <= cell_in.divisor;
      cell_ff.depth   <= cell_in.depth;
   end

   assign cell_out = cell_ff;

endmodule

// ===== rtl/core/ppp_cell.sv =====
module ppp_cell (
   input  logic              clock,
   input  logic              reset,
   input  ppp_pkg::cell_type cell_prev,
   output ppp_pkg::cell_type cell_next
);
   import ppp_pkg::*;

   cell_type          cell_ff, cell_in;
   logic [WORD_W:0]   part_u, part_v;
   logic              ge_u, ge_v;

   // one restoring division step for both axes
   always_comb begin
      part_u  = {cell_prev.rem_u, cell_prev.acc_u[MAG_W-1]};
      part_v  = {cell_prev.rem_v, cell_prev.acc_v[MAG_W-1]};
      ge_u    = part_u >= {1'b0, cell_prev.divisor};
      ge_v    = part_v >= {1'b0, cell_prev.divisor};
      cell_in = cell_prev;
      cell_in.rem_u = ge_u ? WORD_W'(part_u - {1'b0, cell_prev.divisor}) : WORD_W'(part_u);
      cell_in.rem_v = ge_v ? WORD_W'(part_v - {1'b0, cell_prev.divisor}) : WORD_W'(part_v);
      cell_in.acc_u = {cell_prev.acc_u[MAG_W-2:0], ge_u};
      cell_in.acc_v = {cell_prev.acc_v[MAG_W-2:0], ge_v};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.zero    <= cell_in.zero;
      cell_ff.neg_u   <= cell_in.neg_u;
      cell_ff.neg_v   <= cell_in.neg_v;
      cell_ff.acc_u   <= cell_in.acc_u;
      cell_ff.acc_v   <= cell_in.acc_v;
      cell_ff.rem_u   <= cell_in.rem_u;
      cell_ff.rem_v   <= cell_in.rem_v;
      cell_ff.divisor <= cell_in.divisor;
      cell_ff.depth   <= cell_in.depth;
   end

   assign cell_next = cell_ff;

endmodule

// ===== rtl/core/ppp_out.sv =====
module ppp_out (
   input  logic              clock,
   input  logic              reset,
   input  ppp_pkg::cell_type cell_last,
   input  ppp_pkg::cfg_type  cfg,
   output logic              strobe,
   output ppp_pkg::rsp_type  rsp
);
   import ppp_pkg::*;

   logic                     strobe_ff;
   rsp_type                  rsp_ff, rsp_in;
   logic signed [MAG_W:0]    quo_u, quo_v;
   logic signed [PROD_W:0]   sum_u, sum_v;
   logic                     sat_u, sat_v;
   logic signed [WORD_W-1:0] clip_u, clip_v;

   always_comb begin
      quo_u = cell_last.neg_u ? -$signed({1'b0, cell_last.acc_u}) : $signed({1'b0, cell_last.acc_u});
      quo_v = cell_last.neg_v ? -$signed({1'b0, cell_last.acc_v}) : $signed({1'b0, cell_last.acc_v});
      sum_u = $signed({quo_u[MAG_W], quo_u}) + $signed({{(PROD_W+1-REG_W){1'b0}}, cfg.center_x});
      sum_v = $signed({quo_v[MAG_W], quo_v}) + $signed({{(PROD_W+1-REG_W){1'b0}}, cfg.center_y});
      // out of range when the bits above the sign differ from it
      sat_u = (sum_u[PROD_W:WORD_W-1] != '0) && (sum_u[PROD_W:WORD_W-1] != '1);
      sat_v = (sum_v[PROD_W:WORD_W-1] != '0) && (sum_v[PROD_W:WORD_W-1] != '1);
      clip_u = sat_u ? (sum_u[PROD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}})
                     : sum_u[WORD_W-1:0];
      clip_v = sat_v ? (sum_v[PROD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}})
                     : sum_v[WORD_W-1:0];
      if (cell_last.zero) begin
         rsp_in.pixel_u   = '0;
         rsp_in.pixel_v   = '0;
         rsp_in.depth_out = '0;
         rsp_in.status    = STATUS_ZERO;
      end else begin
         rsp_in.pixel_u   = clip_u;
         rsp_in.pixel_v   = clip_v;
         rsp_in.depth_out = cell_last.depth;
         rsp_in.status    = (sat_u || sat_v) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cell_last.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign strobe = strobe_ff;
   assign rsp    = rsp_ff;

endmodule

// ===== rtl/core/pinhole_point_projection_unit.sv =====
// pinhole point projection
// channels: a point item enters on req while start is high and busy is low;
// busy stays low, so one item can be taken every cycle. each result item
// shows on rsp for one cycle with rsp_strobe high and must be taken then,
// the receiver has no way to stall the block.
// csr port: csr_we with csr_index selects focal_x, focal_y, center_x or
// center_y; all 31 bits of csr_wdata are written. write only while idle.
// pipeline: one multiply stage, one magnitude stage, 62 divider cells (one
// quotient bit each) and one output stage with center add and saturation.
// throughput: one item per cycle, set by the divider cell chain, in which
// every cell is registered and takes a new item each cycle.
// reset: clears all item valid bits and loads the default intrinsics
// (focal 525.0, center 319.5 / 239.5). zero depth gives zero pixels,
// zero depth_out and zero-depth status; overflowing pixels clamp and flag.
module pinhole_point_projection_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  ppp_pkg::req_type             req,
   output logic                         rsp_strobe,
   output ppp_pkg::rsp_type             rsp,
   input  logic                         csr_we,
   input  ppp_pkg::csr_index_type       csr_index,
   input  logic [ppp_pkg::REG_W-1:0]    csr_wdata
);
   import ppp_pkg::*;

   cfg_type  cfg_ff;
   cell_type chain [DIV_CELLS+1];
   logic     accept;

   // never stalls: every cycle can take an item
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // intrinsics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x  <= FOCAL_RESET;
         cfg_ff.focal_y  <= FOCAL_RESET;
         cfg_ff.center_x <= CENTER_X_RESET;
         cfg_ff.center_y <= CENTER_Y_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FOCAL_X:  cfg_ff.focal_x  <= csr_wdata;
            CSR_FOCAL_Y:  cfg_ff.focal_y  <= csr_wdata;
            CSR_CENTER_X: cfg_ff.center_x <= csr_wdata;
            CSR_CENTER_Y: cfg_ff.center_y <= csr_wdata;
            default: ;
         endcase
      end
   end

   // products and magnitudes feed the head of the chain
   ppp_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req),
      .cfg      (cfg_ff),
      .cell_out (chain[0])
   );

   // divider chain, one quotient bit per cell
   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
      ppp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_prev (chain[i]),
         .cell_next (chain[i+1])
      );
   end

   // sign, center add, saturation
   ppp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .cell_last (chain[DIV_CELLS]),
      .cfg       (cfg_ff),
      .strobe    (rsp_strobe),
      .rsp       (rsp)
   );

`ifndef SYNTH
   // every result traces back to an earlier item taken on start
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("result without matching item");

   // zero-depth results carry no pixels and no depth
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.status == STATUS_ZERO) |->
         (rsp.pixel_u == '0 && rsp.pixel_v == '0 && rsp.depth_out == '0))
      else $error("zero-depth result not cleared");

   // any status other than zero depth needs a nonzero depth
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.status != STATUS_ZERO) |-> (rsp.depth_out != '0))
      else $error("projected result with zero depth");
`endif

endmodule
